>>> hw/rtl/symmetric_3x3_convolution_filter_defines.svh
// Assertion macros for the 3x3 convolution filter.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef SYMMETRIC_3X3_CONVOLUTION_FILTER_DEFINES_SVH
`define SYMMETRIC_3X3_CONVOLUTION_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
`define SCF_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("scf: invariant violated");
`define SCF_ASSERT_IMPLY(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("scf: implication violated");
`else
`define SCF_ASSERT_ALWAYS(lbl, expr)
`define SCF_ASSERT_IMPLY(lbl, pre, post)
`endif
`endif

>>> hw/rtl/scf_pkg.sv
// Shared types and constants of the 3x3 convolution filter.
// No dependencies.
`default_nettype none
package scf_pkg;
    localparam int QDEPTH = 4;
    localparam int QCW    = $clog2(QDEPTH + 1);
    localparam int QAW    = $clog2(QDEPTH);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MODE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_WEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_WEIGHT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_WEIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 3'd5;

    localparam logic [7:0] GRAY_R = 8'd77;
    localparam logic [7:0] GRAY_G = 8'd150;
    localparam logic [7:0] GRAY_B = 8'd29;

    typedef logic [23:0] t_rgb;

    typedef struct packed {
        logic [11:0]        image_width;
        logic               edge_mode;
        logic signed [11:0] corner_weight;
        logic signed [11:0] side_weight;
        logic signed [11:0] center_weight;
        logic [7:0]         edge_threshold;
    } t_cfg;

    // win[3*row+col], rows top to bottom; e1: window as is, e2: right-border copy
    typedef struct packed {
        t_rgb [8:0] win;
        logic       e1;
        logic       e2;
        logic       fd;
    } t_job;
endpackage
`default_nettype wire

>>> hw/rtl/scf_queue.sv
// Short job queue between front and back of the convolution filter.
// Depends on scf_pkg.
`default_nettype none
module scf_queue import scf_pkg::*; (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire t_job           i_job,
    input  wire logic           i_pop,
    output t_job                o_head,
    output logic [QCW-1:0]      o_cnt
);
    t_job            r_mem [QDEPTH];
    logic [QAW-1:0]  r_wp;
    logic [QAW-1:0]  r_rp;
    logic [QCW-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop) r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_head = r_mem[r_rp];
    assign o_cnt  = r_cnt;
endmodule
`default_nettype wire

>>> hw/rtl/scf_front.sv
// Front of the convolution filter: accepts pixels and flushes, keeps the
// line stores and the 3x3 window, and posts jobs. Depends on scf_pkg.
`default_nettype none
module scf_front import scf_pkg::*; #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_cfg            i_cfg,
    input  wire logic            i_cfg_we,
    input  wire logic            i_valid,
    input  wire logic            i_opcode,
    input  wire logic            i_sof,
    input  wire logic [7:0]      i_red,
    input  wire logic [7:0]      i_green,
    input  wire logic [7:0]      i_blue,
    input  wire logic [QCW-1:0]  i_q_cnt,
    output logic                 o_stall,
    output logic                 o_push,
    output t_job                 o_job
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int XW = (WW > 12) ? WW : 12;

    typedef enum logic [2:0] {S1_NONE, S1_PIX, S1_FL0, S1_FL1, S1_FL2, S1_FLS} t_s1;
    typedef enum logic [1:0] {SQ_IDLE, SQ_C, SQ_CR} t_seq;

    t_rgb r_upper [MAX_WIDTH];
    t_rgb r_middle [MAX_WIDTH];

    logic [CW-1:0] r_cc;
    logic [1:0]    r_rs;
    logic [WW-1:0] r_pend;
    t_seq          r_seq;
    logic          r_fl_ok;
    logic [CW-1:0] r_fl_c;
    logic [CW-1:0] r_fl_cr;
    logic          r_fl_fd;

    t_s1           r_s1_kind;
    logic [CW-1:0] r_s1_k;
    logic          r_s1_k0;
    logic          r_s1_rs0;
    logic          r_s1_e1;
    logic          r_s1_e2;
    t_rgb          r_s1_p;

    t_rgb          r_rd_up;
    t_rgb          r_rd_mid;
    logic          r_byp;
    t_rgb          r_byp_up;
    t_rgb          r_byp_mid;

    t_rgb [8:0]    r_win;
    t_rgb [2:0]    r_fw_up;
    t_rgb [2:0]    r_fw_mid;

    logic [XW-1:0] iw_x;
    logic [XW-1:0] w_x;
    logic [WW-1:0] w;
    logic          ready;
    logic          accept;
    logic          pix;
    logic          fl;
    logic [CW-1:0] cc_e;
    logic [1:0]    rs_e;
    logic [WW-1:0] pend_e;
    logic          end_row;
    logic          fl_eff;
    logic          fl_cont;
    logic [WW-1:0] c_w;
    logic [CW-1:0] c;
    logic [CW-1:0] cl;
    logic [CW-1:0] cr;
    logic [15:0]   gsum;
    t_rgb          p_in;
    logic [CW-1:0] rd_addr;
    t_s1           n_s1_kind;
    t_seq          n_seq;

    t_rgb          up_rd;
    t_rgb          mid_rd;
    t_rgb [2:0]    v;
    t_rgb [8:0]    n_win;
    logic          wr_en;
    t_rgb          fw0_up;
    t_rgb          fw0_mid;
    t_rgb          fw1_up;
    t_rgb          fw1_mid;

    always_comb begin
        iw_x = XW'(i_cfg.image_width);
        if (iw_x == '0) w_x = XW'(1);
        else if (iw_x > XW'(MAX_WIDTH)) w_x = XW'(MAX_WIDTH);
        else w_x = iw_x;
        w = WW'(w_x);

        ready  = (r_seq == SQ_IDLE) && ((QCW + 1)'(i_q_cnt) +
                 (QCW + 1)'(r_s1_kind != S1_NONE) < (QCW + 1)'(QDEPTH));
        accept = i_valid && ready;
        pix    = accept && !i_opcode;
        fl     = accept && i_opcode;

        cc_e    = i_sof ? '0 : r_cc;
        rs_e    = i_sof ? '0 : r_rs;
        pend_e  = i_sof ? '0 : r_pend;
        end_row = (WW'(cc_e) + WW'(1)) >= w;

        fl_eff  = (r_cc == '0) && (r_rs != '0) && (r_pend != '0);
        c_w     = (r_pend >= w) ? '0 : w - r_pend;
        c       = CW'(c_w);
        cl      = (c != '0) ? c - 1'b1 : '0;
        cr      = ((c_w + WW'(1)) < w) ? c + 1'b1 : CW'(w - WW'(1));
        fl_cont = r_fl_ok && (c_w == WW'(r_fl_c) + WW'(1));

        gsum = 16'(GRAY_R) * 16'(i_red) + 16'(GRAY_G) * 16'(i_green)
             + 16'(GRAY_B) * 16'(i_blue) + 16'd128;
        p_in = i_cfg.edge_mode ? {3{gsum[15:8]}} : {i_red, i_green, i_blue};

        unique case (r_seq)
            SQ_C: begin
                rd_addr   = r_fl_c;
                n_s1_kind = S1_FL1;
                n_seq     = SQ_CR;
            end
            SQ_CR: begin
                rd_addr   = r_fl_cr;
                n_s1_kind = S1_FL2;
                n_seq     = SQ_IDLE;
            end
            default: begin
                rd_addr   = fl ? (fl_cont ? cr : cl) : cc_e;
                n_s1_kind = S1_NONE;
                n_seq     = SQ_IDLE;
                if (pix) begin
                    n_s1_kind = S1_PIX;
                end else if (fl && fl_eff) begin
                    n_s1_kind = fl_cont ? S1_FLS : S1_FL0;
                    n_seq     = fl_cont ? SQ_IDLE : SQ_C;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc      <= '0;
            r_rs      <= '0;
            r_pend    <= '0;
            r_seq     <= SQ_IDLE;
            r_fl_ok   <= 1'b0;
            r_s1_kind <= S1_NONE;
        end else begin
            r_seq     <= n_seq;
            r_s1_kind <= n_s1_kind;
            if (pix) begin
                r_fl_ok <= 1'b0;
                if (end_row) begin
                    r_cc   <= '0;
                    r_rs   <= (rs_e == 2'd2) ? rs_e : rs_e + 1'b1;
                    r_pend <= w;
                end else begin
                    r_cc   <= cc_e + 1'b1;
                    r_rs   <= rs_e;
                    r_pend <= pend_e;
                end
            end else if (fl && fl_eff) begin
                r_pend  <= r_pend - 1'b1;
                r_fl_ok <= !i_cfg_we;
            end else if (i_cfg_we) begin
                r_fl_ok <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fl && fl_eff) begin
            r_fl_c  <= c;
            r_fl_cr <= cr;
            r_fl_fd <= (r_pend == WW'(1));
        end
        if (pix) begin
            r_s1_k   <= cc_e;
            r_s1_k0  <= (cc_e == '0);
            r_s1_rs0 <= (rs_e == '0);
            r_s1_e1  <= (rs_e != '0) && (cc_e != '0);
            r_s1_e2  <= (rs_e != '0) && end_row;
            r_s1_p   <= p_in;
        end
    end

    // line stores, read data registered, same-edge write forwarded
    assign wr_en = (r_s1_kind == S1_PIX);

    always_ff @(posedge i_clk) begin
        if (wr_en) r_upper[r_s1_k] <= v[1];
        r_rd_up <= r_upper[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_middle[r_s1_k] <= r_s1_p;
        r_rd_mid <= r_middle[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_byp     <= wr_en && (r_s1_k == rd_addr);
        r_byp_up  <= v[1];
        r_byp_mid <= r_s1_p;
    end

    always_comb begin
        up_rd  = r_byp ? r_byp_up : r_rd_up;
        mid_rd = r_byp ? r_byp_mid : r_rd_mid;
        v[0]   = r_s1_rs0 ? r_s1_p : up_rd;
        v[1]   = r_s1_rs0 ? r_s1_p : mid_rd;
        v[2]   = r_s1_p;
        for (int i = 0; i < 3; i++) begin
            n_win[3*i]   = r_s1_k0 ? v[i] : r_win[3*i+1];
            n_win[3*i+1] = r_s1_k0 ? v[i] : r_win[3*i+2];
            n_win[3*i+2] = v[i];
        end

        fw0_up  = (r_s1_kind == S1_FLS) ? r_fw_up[1]  : r_fw_up[0];
        fw0_mid = (r_s1_kind == S1_FLS) ? r_fw_mid[1] : r_fw_mid[0];
        fw1_up  = (r_s1_kind == S1_FLS) ? r_fw_up[2]  : r_fw_up[1];
        fw1_mid = (r_s1_kind == S1_FLS) ? r_fw_mid[2] : r_fw_mid[1];

        o_push = 1'b0;
        o_job  = '0;
        case (r_s1_kind)
            S1_PIX: begin
                o_push    = r_s1_e1 || r_s1_e2;
                o_job.win = n_win;
                o_job.e1  = r_s1_e1;
                o_job.e2  = r_s1_e2;
            end
            S1_FL2, S1_FLS: begin
                o_push    = 1'b1;
                o_job.win = {mid_rd, fw1_mid, fw0_mid, mid_rd, fw1_mid, fw0_mid,
                             up_rd, fw1_up, fw0_up};
                o_job.e1  = 1'b1;
                o_job.fd  = r_fl_fd;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (wr_en) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_s1_kind)
            S1_FL0: begin
                r_fw_up[0]  <= up_rd;
                r_fw_mid[0] <= mid_rd;
            end
            S1_FL1: begin
                r_fw_up[1]  <= up_rd;
                r_fw_mid[1] <= mid_rd;
            end
            S1_FL2: begin
                r_fw_up[2]  <= up_rd;
                r_fw_mid[2] <= mid_rd;
            end
            S1_FLS: begin
                r_fw_up     <= {up_rd, r_fw_up[2], r_fw_up[1]};
                r_fw_mid    <= {mid_rd, r_fw_mid[2], r_fw_mid[1]};
            end
            default: begin
            end
        endcase
    end

    assign o_stall = !ready;
endmodule
`default_nettype wire

>>> hw/rtl/scf_back.sv
// Back of the convolution filter: weighted sums, rounding, clamp and
// threshold, three register stages. Depends on scf_pkg.
`default_nettype none
module scf_back import scf_pkg::*; #(
    parameter int WEIGHT_FRAC_BITS = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire t_job  i_job,
    input  wire logic  i_q_valid,
    input  wire logic  i_stall,
    output logic       o_pop,
    output logic       o_valid,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    output logic       o_frame_done,
    output logic       o_last
);
    localparam int SW = 26;
    localparam logic signed [SW-1:0] RND = SW'(1) <<< (WEIGHT_FRAC_BITS - 1);

    logic r_second;

    logic       r1_v;
    logic [9:0] r1_cs [3];
    logic [9:0] r1_ss [3];
    logic [7:0] r1_cm [3];
    logic       r1_fd;
    logic       r1_last;

    logic              r2_v;
    logic signed [22:0] r2_pc [3];
    logic signed [22:0] r2_ps [3];
    logic signed [22:0] r2_pm [3];
    logic              r2_fd;
    logic              r2_last;

    logic       r3_v;
    logic [7:0] r3_q [3];
    logic       r3_fd;
    logic       r3_last;

    logic       adv1;
    logic       adv2;
    logic       adv3;
    logic       second;
    logic       last_sel;
    t_rgb [8:0] sw;
    logic [9:0] cs [3];
    logic [9:0] ss [3];
    logic [7:0] cm [3];
    logic signed [SW-1:0] t [3];
    logic signed [SW-1:0] sh [3];
    logic [7:0] q [3];

    always_comb begin
        adv3     = !r3_v || !i_stall;
        adv2     = !r2_v || adv3;
        adv1     = !r1_v || adv2;
        second   = r_second || !i_job.e1;
        last_sel = second || !i_job.e2;
        o_pop    = adv1 && i_q_valid && last_sel;
        for (int r = 0; r < 3; r++) begin
            sw[3*r]   = second ? i_job.win[3*r+1] : i_job.win[3*r];
            sw[3*r+1] = second ? i_job.win[3*r+2] : i_job.win[3*r+1];
            sw[3*r+2] = i_job.win[3*r+2];
        end
        for (int ch = 0; ch < 3; ch++) begin
            cs[ch] = 10'(sw[0][(2-ch)*8 +: 8]) + 10'(sw[2][(2-ch)*8 +: 8])
                   + 10'(sw[6][(2-ch)*8 +: 8]) + 10'(sw[8][(2-ch)*8 +: 8]);
            ss[ch] = 10'(sw[1][(2-ch)*8 +: 8]) + 10'(sw[3][(2-ch)*8 +: 8])
                   + 10'(sw[5][(2-ch)*8 +: 8]) + 10'(sw[7][(2-ch)*8 +: 8]);
            cm[ch] = sw[4][(2-ch)*8 +: 8];
            t[ch]  = SW'(r2_pc[ch]) + SW'(r2_ps[ch]) + SW'(r2_pm[ch]) + RND;
            sh[ch] = t[ch] >>> WEIGHT_FRAC_BITS;
            if (t[ch][SW-1]) q[ch] = 8'd0;
            else if (sh[ch] > SW'(255)) q[ch] = 8'd255;
            else q[ch] = sh[ch][7:0];
            if (i_cfg.edge_mode) q[ch] = (q[ch] > i_cfg.edge_threshold) ? 8'd255 : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
            r1_v     <= 1'b0;
            r2_v     <= 1'b0;
            r3_v     <= 1'b0;
        end else begin
            if (adv1) begin
                r1_v <= i_q_valid;
                if (i_q_valid) r_second <= !last_sel;
            end
            if (adv2) r2_v <= r1_v;
            if (adv3) r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_cs   <= cs;
            r1_ss   <= ss;
            r1_cm   <= cm;
            r1_fd   <= i_job.fd;
            r1_last <= last_sel;
        end
        if (adv2) begin
            for (int ch = 0; ch < 3; ch++) begin
                r2_pc[ch] <= $signed(i_cfg.corner_weight) * $signed({1'b0, r1_cs[ch]});
                r2_ps[ch] <= $signed(i_cfg.side_weight) * $signed({1'b0, r1_ss[ch]});
                r2_pm[ch] <= $signed(i_cfg.center_weight) * $signed({3'b000, r1_cm[ch]});
            end
            r2_fd   <= r1_fd;
            r2_last <= r1_last;
        end
        if (adv3) begin
            r3_q    <= q;
            r3_fd   <= r2_fd;
            r3_last <= r2_last;
        end
    end

    assign o_valid      = r3_v;
    assign o_red        = r3_q[0];
    assign o_green      = r3_q[1];
    assign o_blue       = r3_q[2];
    assign o_frame_done = r3_fd;
    assign o_last       = r3_last;
endmodule
`default_nettype wire

>>> hw/rtl/symmetric_3x3_convolution_filter.sv
// Symmetric 3x3 RGB convolution with replicated borders.
// Path: front stage register, job queue, back stages r1 to r3. Throughput:
// one item per cycle while o_stall is low; a row-end pixel gives two
// results; the first flush of a drain takes three store reads.
// Reset: synchronous, active low; clears counters, pipeline and config
// registers to their defaults. Line stores are not cleared.
`default_nettype none
`include "symmetric_3x3_convolution_filter_defines.svh"
module symmetric_3x3_convolution_filter import scf_pkg::*; #(
    parameter int MAX_WIDTH        = 2048,
    parameter int WEIGHT_FRAC_BITS = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_opcode,
    input  wire logic                  i_start_of_frame,
    input  wire logic [7:0]            i_red_in,
    input  wire logic [7:0]            i_green_in,
    input  wire logic [7:0]            i_blue_in,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [7:0]                 o_red_out,
    output logic [7:0]                 o_green_out,
    output logic [7:0]                 o_blue_out,
    output logic                       o_frame_done,
    output logic                       o_last_of_burst
);
    t_cfg           r_cfg;
    logic           q_push;
    logic           q_pop;
    t_job           q_in;
    t_job           q_head;
    logic [QCW-1:0] q_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width    <= 12'd640;
            r_cfg.edge_mode      <= 1'b0;
            r_cfg.corner_weight  <= 12'sd0;
            r_cfg.side_weight    <= -12'sd256;
            r_cfg.center_weight  <= 12'sd1280;
            r_cfg.edge_threshold <= 8'd128;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_WIDTH:    r_cfg.image_width    <= i_cfg_data;
                CFG_EDGE_MODE:      r_cfg.edge_mode      <= i_cfg_data[0];
                CFG_CORNER_WEIGHT:  r_cfg.corner_weight  <= i_cfg_data;
                CFG_SIDE_WEIGHT:    r_cfg.side_weight    <= i_cfg_data;
                CFG_CENTER_WEIGHT:  r_cfg.center_weight  <= i_cfg_data;
                CFG_EDGE_THRESHOLD: r_cfg.edge_threshold <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    scf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_cfg_we (i_cfg_we),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .i_sof    (i_start_of_frame),
        .i_red    (i_red_in),
        .i_green  (i_green_in),
        .i_blue   (i_blue_in),
        .i_q_cnt  (q_cnt),
        .o_stall  (o_stall),
        .o_push   (q_push),
        .o_job    (q_in)
    );

    scf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_cnt   (q_cnt)
    );

    scf_back #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_job        (q_head),
        .i_q_valid    (q_cnt != '0),
        .i_stall      (i_stall),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .o_red        (o_red_out),
        .o_green      (o_green_out),
        .o_blue       (o_blue_out),
        .o_frame_done (o_frame_done),
        .o_last       (o_last_of_burst)
    );

    `SCF_ASSERT_IMPLY(a_no_overflow, q_push, q_cnt != QCW'(QDEPTH))
    `SCF_ASSERT_IMPLY(a_no_underflow, q_pop, q_cnt != '0)
    `SCF_ASSERT_IMPLY(a_done_is_last, o_valid && o_frame_done, o_last_of_burst)
endmodule
`default_nettype wire
